### rtl/kmde_pkg.sv
// Shared types and constants of the key matrix debounce and event queue block.
package kmde_pkg;

   // Field widths of the stream payloads
   localparam int ROW_W      = 2;
   localparam int LEVEL_W    = 3;
   localparam int POS_W      = 4;
   localparam int KIND_W     = 2;
   localparam int THR_W      = 4;
   localparam int CNT_W      = 4;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 3;

   // Request selector
   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // Event kinds on the response
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   localparam logic [THR_W-1:0] THR_RESET = 4'd2;
   localparam logic [CNT_W-1:0] CNT_MAX   = 4'd15;

   typedef struct packed {
      logic start;      // latch a scan request
      logic key_rd;     // read next key of the row, advance column
      logic pop;        // read queue head
      logic load_rsp;   // load response register
   } kmde_cmd_type;

   typedef struct packed {
      logic row_ok;     // request row is inside the matrix
      logic col_last;   // current column is the last one
      logic rsp_busy;   // response register stays occupied this cycle
   } kmde_sts_type;

   typedef struct packed {
      logic             is_release;
      logic [POS_W-1:0] pos;
   } kmde_event_type;

   typedef struct packed {
      logic             stable;
      logic [CNT_W-1:0] count;
   } kmde_key_type;

endpackage

### rtl/kmde_ctrl.sv
// Controller state machine: sequences scan and read requests.
module kmde_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tuser,   // [0] mode
   output logic                   req_tready,
   input  kmde_pkg::kmde_sts_type sts,
   output kmde_pkg::kmde_cmd_type cmd
);
   import kmde_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;
   localparam logic [1:0] ST_LOAD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == MODE_READ) begin
                  state_in = ST_POP;
               end else if (sts.row_ok) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.key_rd = 1'b1;
            if (sts.col_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            // hold until the response register frees up
            if (!sts.rsp_busy) begin
               cmd.pop  = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.key_rd, cmd.pop, cmd.load_rsp}))
      else $error("more than one datapath command at once");

   a_pop_then_load: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> cmd.load_rsp)
      else $error("queue read not followed by response load");

   a_start_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (req_tvalid && req_tready))
      else $error("row walk started without a request transfer");
`endif

endmodule

### rtl/kmde_dp.sv
// Datapath: key state memory, debounce update, event queue and response register.
module kmde_dp #(
   parameter int ROW_COUNT    = 3,
   parameter int COLUMN_COUNT = 3,
   parameter int QUEUE_DEPTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kmde_pkg::kmde_cmd_type              cmd,
   output kmde_pkg::kmde_sts_type              sts,
   input  logic [kmde_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_valid,
   input  logic [kmde_pkg::THR_W-1:0]          csr_data,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [kmde_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [kmde_pkg::RSP_USER_W-1:0]     rsp_tuser
);
   import kmde_pkg::*;

   localparam int KEYS = ROW_COUNT * COLUMN_COUNT;
   localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int CW   = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
   localparam int PW   = $clog2(QUEUE_DEPTH);

   logic [ROW_W-1:0]   req_row;
   logic [LEVEL_W-1:0] req_levels;

   assign req_row    = req_tdata[ROW_W-1:0];
   assign req_levels = req_tdata[ROW_W+LEVEL_W-1:ROW_W];

   // Threshold register
   logic [THR_W-1:0] thr_ff;
   logic [THR_W-1:0] limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   assign limit = (thr_ff == '0) ? THR_W'(1) : thr_ff;

   // Row walk: key address, column counter, level shifter
   logic [KW-1:0]      key_ff, key_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [LEVEL_W-1:0] lv_ff, lv_in;

   always_comb begin
      key_in = key_ff;
      col_in = col_ff;
      lv_in  = lv_ff;
      if (cmd.start) begin
         key_in = KW'(int'(req_row) * COLUMN_COUNT);
         col_in = '0;
         lv_in  = req_levels;
      end else if (cmd.key_rd) begin
         key_in = key_ff + KW'(1);
         col_in = col_ff + CW'(1);
         lv_in  = lv_ff >> 1;   // columns past the field read as pressed
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      col_ff <= col_in;
      lv_ff  <= lv_in;
   end

   // Key state memory with per-entry valid bits
   kmde_key_type  key_mem [KEYS];
   logic [KEYS-1:0] key_vld_ff;
   kmde_key_type  key_rd_ff;
   logic          key_hit_ff;
   logic          wb_ff;
   logic [KW-1:0] wb_key_ff;
   logic          wb_raw_ff;

   kmde_key_type   cur;
   kmde_key_type   key_new;
   logic [CNT_W-1:0] cnt_inc;
   logic           flip;
   logic           push_req;
   kmde_event_type entry;

   always_ff @(posedge clock) begin
      if (cmd.key_rd) begin
         key_rd_ff <= key_mem[key_ff];
      end
      if (wb_ff) begin
         key_mem[wb_key_ff] <= key_new;
      end
   end

   always_ff @(posedge clock) begin
      key_hit_ff <= key_vld_ff[key_ff];
      wb_key_ff  <= key_ff;
      wb_raw_ff  <= ~lv_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff <= '0;
         wb_ff      <= 1'b0;
      end else begin
         wb_ff <= cmd.key_rd;
         if (wb_ff) begin
            key_vld_ff[wb_key_ff] <= 1'b1;
         end
      end
   end

   always_comb begin
      cur            = key_hit_ff ? key_rd_ff : '0;
      cnt_inc        = (cur.count == CNT_MAX) ? CNT_MAX : cur.count + CNT_W'(1);
      flip           = (wb_raw_ff != cur.stable) && (cnt_inc >= limit);
      key_new.stable = flip ? wb_raw_ff : cur.stable;
      key_new.count  = ((wb_raw_ff == cur.stable) || flip) ? '0 : cnt_inc;
      push_req       = wb_ff && flip;
      entry.is_release = ~wb_raw_ff;
      entry.pos        = POS_W'(wb_key_ff);
   end

   // Event queue
   kmde_event_type q_mem [QUEUE_DEPTH];
   kmde_event_type q_rd_ff;
   logic [PW-1:0]  wp_ff, rp_ff;
   logic [PW-1:0]  wp_next, rp_next;
   logic           q_full, q_empty, push_ok, pop_ok;
   logic           pop_hit_ff;

   assign wp_next = (wp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
   assign rp_next = (rp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + PW'(1);
   assign q_full  = (wp_next == rp_ff);
   assign q_empty = (wp_ff == rp_ff);
   assign push_ok = push_req && !q_full;
   assign pop_ok  = cmd.pop && !q_empty;

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mem[wp_ff] <= entry;
      end
      if (cmd.pop) begin
         q_rd_ff <= q_mem[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         rp_ff      <= '0;
         pop_hit_ff <= 1'b0;
      end else begin
         if (push_ok) begin
            wp_ff <= wp_next;
         end
         if (pop_ok) begin
            rp_ff <= rp_next;
         end
         pop_hit_ff <= pop_ok;
      end
   end

   // Response register
   logic              rsp_valid_ff;
   logic              ev_valid_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [POS_W-1:0]  pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         ev_valid_ff <= pop_hit_ff;
         kind_ff     <= !pop_hit_ff ? KIND_NONE :
                        (q_rd_ff.is_release ? KIND_RELEASE : KIND_PRESS);
         pos_ff      <= pop_hit_ff ? q_rd_ff.pos : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - POS_W)'(0), pos_ff};
   assign rsp_tuser  = {kind_ff, ev_valid_ff};

   assign sts.row_ok   = (int'(req_row) < ROW_COUNT);
   assign sts.col_last = (col_ff == CW'(COLUMN_COUNT - 1));
   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;

`ifndef ASSERT_OFF
   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      push_ok |=> (wp_ff != rp_ff))
      else $error("queue looks empty right after a push");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid_ff)
      else $error("response register overwritten while occupied");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !ev_valid_ff) |-> (kind_ff == KIND_NONE && pos_ff == '0))
      else $error("empty read carries a nonzero event");
`endif

endmodule

### rtl/key_matrix_debounce_event_queue.sv
// Top level of the key matrix debouncer with press and release event queue.
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser: mode; tdata: row, col_levels
//  rsp      out  rsp_tvalid/tready    tuser: event_valid, event_kind; tdata: key_position
//  csr      in   csr_valid/ready      csr_data: debounce_threshold
//
// A scan transfer accepts the request, then the controller walks the
// row one column per cycle through the key state memory (one read port, one
// write port), so each column yields at most one queue push.
// A read transfer steps through accept, queue read and response load; the queue
// read waits while the previous response is still held in the output register.
// A scan with a row outside the matrix is accepted and dropped.
// Reset is synchronous and clears the key valid bits, queue pointers and
// controller at once; no clearing pass is needed. csr_ready is always high.
module key_matrix_debounce_event_queue #(
   parameter int ROW_COUNT    = 3,
   parameter int COLUMN_COUNT = 3,
   parameter int QUEUE_DEPTH  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kmde_pkg::REQ_DATA_W-1:0]  req_tdata,   // [1:0] row, [4:2] col_levels
   input  logic                             req_tuser,   // [0] mode
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kmde_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [3:0] key_position
   output logic [kmde_pkg::RSP_USER_W-1:0]  rsp_tuser,   // [0] event_valid, [2:1] event_kind
   // threshold write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kmde_pkg::THR_W-1:0]       csr_data
);
   import kmde_pkg::*;

   kmde_cmd_type cmd;
   kmde_sts_type sts;

   // Take threshold writes at any time; the host must write only while idle (not enforced here).
   assign csr_ready = 1'b1;

   // Controller: decodes the request, walks columns, orders queue read
   // and response load.
   kmde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: debounce counters, event queue and response register.
   kmde_dp #(
      .ROW_COUNT    (ROW_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
